// ===== sv/otsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared types and codes of the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
package otsu_pkg;

  localparam int unsigned NUM_BINS = 256;
  localparam logic [7:0]  LAST_BIN = 8'd255;

  localparam logic [1:0] CMD_ACCUM    = 2'd0;
  localparam logic [1:0] CMD_FINISH   = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  localparam logic KIND_THRESHOLD = 1'b0;
  localparam logic KIND_PIXEL     = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] threshold_value;
    logic       pixel_bit;
  } out_word_t;

endpackage

// ===== sv/otsu_threshold_binarizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer
// Histogram-based Otsu binarizer: accumulate, finish (threshold search), classify.
// ----------------------------------------------------------------------------
// Accumulate words: one per unstalled cycle, read-modify-write of the histogram RAM
//   with forwarding between back-to-back hits on one bin.
// Classify words: one per unstalled cycle, result in the cycle after acceptance.
// Finish word: a weighted-sum pass over all bins, then per bin a search pass (read,
//   update, 8-step divider, two multiplier stages, compare); input stalled meanwhile.
// Reset: asynchronous; histogram valid bits, count and threshold cleared.
module otsu_threshold_binarizer #(
  parameter int unsigned MAX_PIXELS_LOG2 = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  otsu_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output otsu_pkg::out_word_t out_word_o
);

  localparam int unsigned CW   = MAX_PIXELS_LOG2 + 1;  // bin and count width
  localparam int unsigned SUMW = CW + 8;               // weighted sums
  localparam int unsigned DSW  = CW + 7;               // divisor shifted by 7
  localparam int unsigned SCW  = 2 * CW + 16;          // score
  localparam logic [CW-1:0] LIMIT = CW'(1) << MAX_PIXELS_LOG2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SUM_RD = 4'd1;
  localparam logic [3:0] S_SUM_AC = 4'd2;
  localparam logic [3:0] S_SC_RD  = 4'd3;
  localparam logic [3:0] S_SC_UPD = 4'd4;
  localparam logic [3:0] S_SC_DIV = 4'd5;
  localparam logic [3:0] S_SC_MU1 = 4'd6;
  localparam logic [3:0] S_SC_MU2 = 4'd7;
  localparam logic [3:0] S_SC_CMP = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;

  // Histogram RAM, per-bin valid bits stand in for clearing.
  logic [CW-1:0] mem [otsu_pkg::NUM_BINS];
  logic [otsu_pkg::NUM_BINS-1:0] vld_q;
  logic [CW-1:0] rdata_q;
  logic          rvld_q;
  logic [7:0]    rd_addr;
  logic          wr_en;
  logic [CW-1:0] wr_data;
  logic          clr_all;

  // Accumulate pipeline stage and forwarding register
  logic          acc_q;
  logic [7:0]    acc_addr_q;
  logic          fwd_q;
  logic [7:0]    fwd_addr_q;
  logic [CW-1:0] fwd_data_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] bin_cur;
  logic [CW-1:0] bin_rd;

  logic [7:0] thr_cur_q;

  // Scan datapath
  logic [7:0]      t_q;
  logic [SUMW-1:0] sum_q, sumb_q, sumb_d;
  logic [CW-1:0]   q1_q, q2_q, q1_d;
  logic [7:0]      m1_q, m2_q;
  logic [SUMW-1:0] rem1_q, rem2_q;
  logic [DSW-1:0]  dsh1_q, dsh2_q;
  logic [7:0]      quo1_q, quo2_q;
  logic            bit1, bit2;
  logic [2:0]      step_q;
  logic [2*CW-1:0] p1_q;
  logic [15:0]     dd_q;
  logic [7:0]      diff;
  logic [SCW-1:0]  score_q, best_q;
  logic [7:0]      thr_q;

  logic      out_valid_q;
  otsu_pkg::out_word_t out_word_q;

  logic in_acc;
  logic out_busy;

  assign out_busy    = out_valid_q && out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || out_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------- histogram memory ----------------
  assign rd_addr = (state_q == S_IDLE) ? in_word_i.pixel_value : t_q;
  assign bin_rd  = rvld_q ? rdata_q : '0;
  assign bin_cur = (fwd_q && (fwd_addr_q == acc_addr_q)) ? fwd_data_q : bin_rd;
  assign wr_en   = acc_q;
  assign wr_data = bin_cur + CW'(1);
  assign clr_all = (state_q == S_DONE) && !out_busy;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[acc_addr_q] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr];
      if (clr_all) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[acc_addr_q] <= 1'b1;
      end
    end
  end

  // ---------------- accumulate pipeline ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 1'b0;
      fwd_q   <= 1'b0;
      count_q <= '0;
    end else begin
      acc_q <= 1'b0;
      fwd_q <= acc_q;
      if (in_acc && (in_word_i.cmd == otsu_pkg::CMD_ACCUM) && (count_q < LIMIT)) begin
        acc_q   <= 1'b1;
        count_q <= count_q + CW'(1);
      end
      if (clr_all) begin
        count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_addr_q <= in_word_i.pixel_value;
    fwd_addr_q <= acc_addr_q;
    fwd_data_q <= wr_data;
  end

  // ---------------- finish sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && (in_word_i.cmd == otsu_pkg::CMD_FINISH)) state_d = S_SUM_RD;
      S_SUM_RD: state_d = S_SUM_AC;
      S_SUM_AC: state_d = (t_q == otsu_pkg::LAST_BIN) ? S_SC_RD : S_SUM_RD;
      S_SC_RD:  state_d = S_SC_UPD;
      S_SC_UPD: state_d = S_SC_DIV;
      S_SC_DIV: if (step_q == 3'd7) state_d = S_SC_MU1;
      S_SC_MU1: state_d = S_SC_MU2;
      S_SC_MU2: state_d = S_SC_CMP;
      S_SC_CMP: state_d = (t_q == otsu_pkg::LAST_BIN) ? S_DONE : S_SC_RD;
      S_DONE:   if (!out_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign q1_d   = q1_q + bin_rd;
  assign sumb_d = sumb_q + SUMW'(t_q) * SUMW'(bin_rd);
  assign bit1   = rem1_q >= SUMW'(dsh1_q);
  assign bit2   = rem2_q >= SUMW'(dsh2_q);
  assign diff   = (m1_q >= m2_q) ? (m1_q - m2_q) : (m2_q - m1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      thr_cur_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_all) begin
        thr_cur_q <= thr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        t_q    <= '0;
        sum_q  <= '0;
        sumb_q <= '0;
        q1_q   <= '0;
        m1_q   <= '0;
        m2_q   <= '0;
        best_q <= '0;
        thr_q  <= '0;
      end
      S_SUM_RD: ;
      S_SUM_AC: begin
        sum_q <= sum_q + SUMW'(t_q) * SUMW'(bin_rd);
        t_q   <= (t_q == otsu_pkg::LAST_BIN) ? 8'd0 : t_q + 8'd1;
      end
      S_SC_RD: ;
      S_SC_UPD: begin
        q1_q   <= q1_d;
        q2_q   <= (count_q >= q1_d) ? (count_q - q1_d) : '0;
        sumb_q <= sumb_d;
        rem1_q <= sumb_d;
        rem2_q <= sum_q - sumb_d;
        dsh1_q <= {q1_d, 7'b0};
        dsh2_q <= {((count_q >= q1_d) ? (count_q - q1_d) : CW'(0)), 7'b0};
        step_q <= '0;
      end
      S_SC_DIV: begin
        if (bit1) rem1_q <= rem1_q - SUMW'(dsh1_q);
        if (bit2) rem2_q <= rem2_q - SUMW'(dsh2_q);
        dsh1_q <= dsh1_q >> 1;
        dsh2_q <= dsh2_q >> 1;
        quo1_q <= {quo1_q[6:0], bit1};
        quo2_q <= {quo2_q[6:0], bit2};
        step_q <= step_q + 3'd1;
        if (step_q == 3'd7) begin
          // an empty class keeps its previous mean
          if (q1_q != '0) m1_q <= {quo1_q[6:0], bit1};
          if (q2_q != '0) m2_q <= {quo2_q[6:0], bit2};
        end
      end
      S_SC_MU1: begin
        p1_q <= q1_q * q2_q;
        dd_q <= diff * diff;
      end
      S_SC_MU2: score_q <= p1_q * dd_q;
      S_SC_CMP: begin
        if (score_q > best_q) begin
          best_q <= score_q;
          thr_q  <= t_q;
        end
        t_q <= t_q + 8'd1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && (in_word_i.cmd == otsu_pkg::CMD_CLASSIFY)) begin
        out_valid_q <= 1'b1;
      end else if (clr_all) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_word_i.cmd == otsu_pkg::CMD_CLASSIFY)) begin
      out_word_q.kind            <= otsu_pkg::KIND_PIXEL;
      out_word_q.threshold_value <= thr_cur_q;
      out_word_q.pixel_bit       <= in_word_i.pixel_value > thr_cur_q;
    end else if (clr_all) begin
      out_word_q.kind            <= otsu_pkg::KIND_THRESHOLD;
      out_word_q.threshold_value <= thr_q;
      out_word_q.pixel_bit       <= 1'b0;
    end
  end

endmodule

// ===== tb/sv/tb_otsu_threshold_binarizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_otsu_threshold_binarizer
// Self-checking bench: streams accumulate, finish and classify words, predicts
// thresholds and pixel bits with an own Otsu search, checks every result word.
// ----------------------------------------------------------------------------
module tb_otsu_threshold_binarizer;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  otsu_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  otsu_pkg::out_word_t out_word_o;

  otsu_threshold_binarizer #(.MAX_PIXELS_LOG2(20)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  localparam longint unsigned PIXEL_LIMIT = 64'd1 << 20;

  // Predictor state: own copy of the histogram, count and stored threshold.
  int unsigned hist_bins [otsu_pkg::NUM_BINS] = '{default: 0};
  int unsigned hist_count = 0;
  logic [7:0]  thr_stored = 8'd0;

  otsu_pkg::in_word_t  pending_words [$];
  otsu_pkg::out_word_t expected_words [$];
  int        error_count = 0;
  bit        quiet_tail;   // no idling on either side near the end
  int        send_gap = 0;
  int        recv_gap = 0;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Otsu search over the predictor histogram; first strict maximum wins.
  function automatic logic [7:0] otsu_search();
    longint unsigned total, sum_all, q1, q2, sum_b, m1, m2, diff, score, best;
    logic [7:0] thr;
    total = hist_count; sum_all = 0; q1 = 0; sum_b = 0;
    m1 = 0; m2 = 0; best = 0; thr = 8'd0;
    for (int t = 0; t < otsu_pkg::NUM_BINS; t++) sum_all += longint'(t) * hist_bins[t];
    for (int t = 0; t < otsu_pkg::NUM_BINS; t++) begin
      q1 += hist_bins[t];
      q2 = (total >= q1) ? total - q1 : 0;
      sum_b += longint'(t) * hist_bins[t];
      if (q1 != 0) m1 = sum_b / q1;
      if (q2 != 0) m2 = (sum_all - sum_b) / q2;
      diff = (m1 >= m2) ? m1 - m2 : m2 - m1;
      score = q1 * q2 * diff * diff;
      if (score > best) begin
        best = score;
        thr = t[7:0];
      end
    end
    return thr;
  endfunction

  // Advance the predictor by one accepted word, queueing any result.
  task automatic predict_word(input otsu_pkg::in_word_t w);
    otsu_pkg::out_word_t r;
    case (w.cmd)
      otsu_pkg::CMD_ACCUM: begin
        if (hist_count < PIXEL_LIMIT) begin
          hist_bins[w.pixel_value]++;
          hist_count++;
        end
      end
      otsu_pkg::CMD_FINISH: begin
        thr_stored = otsu_search();
        foreach (hist_bins[i]) hist_bins[i] = 0;
        hist_count = 0;
        r.kind = otsu_pkg::KIND_THRESHOLD; r.threshold_value = thr_stored;
        r.pixel_bit = 1'b0;
        expected_words.push_back(r);
      end
      otsu_pkg::CMD_CLASSIFY: begin
        r.kind = otsu_pkg::KIND_PIXEL; r.threshold_value = thr_stored;
        r.pixel_bit = (w.pixel_value > thr_stored);
        expected_words.push_back(r);
      end
      default: ;  // unused command: ignored
    endcase
  endtask

  function automatic otsu_pkg::in_word_t make_word(input logic [1:0] c,
                                                   input logic [7:0] v);
    otsu_pkg::in_word_t w;
    w.cmd = c; w.pixel_value = v;
    return w;
  endfunction

  // Driver: present the next pending word at the falling edge; hold it while
  // stalled. Acceptance is judged from values sampled at the rising edge.
  bit in_taken;
  always @(posedge clk_i) in_taken <= in_valid_i && !in_stall_o && rst_ni;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
    end else if (in_taken || !in_valid_i) begin
      if (in_taken && !quiet_tail && (pending_words.size() > 0) &&
          ($urandom_range(0, 7) == 0)) begin
        send_gap = $urandom_range(1, 19);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_word_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall bursts.
  always @(negedge clk_i) begin
    if (!rst_ni || quiet_tail) out_stall_i <= 1'b0;
    else if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else out_stall_i <= 1'b0;
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    otsu_pkg::out_word_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_word(in_word_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) report_mismatch("result word with none expected");
        else begin
          e = expected_words.pop_front();
          if (out_word_o.kind !== e.kind)
            report_mismatch($sformatf("kind %0b exp %0b", out_word_o.kind, e.kind));
          if (out_word_o.threshold_value !== e.threshold_value)
            report_mismatch($sformatf("threshold %0d exp %0d",
                                      out_word_o.threshold_value, e.threshold_value));
          if (out_word_o.pixel_bit !== e.pixel_bit)
            report_mismatch($sformatf("pixel_bit %0b exp %0b",
                                      out_word_o.pixel_bit, e.pixel_bit));
        end
      end
    end
  end

  // Frame of random pixels: bimodal or uniform, then a finish and classifies.
  task automatic queue_frame(input int n_pix, input int n_cls);
    int lo, hi, mode;
    mode = $urandom_range(0, 2);
    lo = $urandom_range(0, 120);
    hi = $urandom_range(135, 255);
    for (int i = 0; i < n_pix; i++) begin
      case (mode)
        0: pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM,
             8'($urandom_range(0, 255))));
        1: pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM,
             8'(($urandom_range(0, 1) != 0) ?
                $urandom_range(lo, lo + 20) : $urandom_range(hi - 20, hi))));
        default: pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM,
             8'($urandom_range(lo, hi))));
      endcase
      if ($urandom_range(0, 40) == 0)
        pending_words.push_back(make_word(otsu_pkg::CMD_UNUSED,
                                          8'($urandom_range(0, 255))));
    end
    pending_words.push_back(make_word(otsu_pkg::CMD_FINISH, 8'($urandom_range(0, 255))));
    for (int i = 0; i < n_cls; i++)
      pending_words.push_back(make_word(otsu_pkg::CMD_CLASSIFY,
                                        8'($urandom_range(0, 255))));
  endtask

  initial begin
    int sent;
    rst_ni = 1'b0; quiet_tail = 1'b0;

    // Directed: classify at reset threshold, empty finish, extremes, unused cmd.
    pending_words.push_back(make_word(otsu_pkg::CMD_CLASSIFY, 8'd0));
    pending_words.push_back(make_word(otsu_pkg::CMD_CLASSIFY, 8'd255));
    pending_words.push_back(make_word(otsu_pkg::CMD_FINISH, 8'd0));
    pending_words.push_back(make_word(otsu_pkg::CMD_UNUSED, 8'd255));
    pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM, 8'd0));
    pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM, 8'd255));
    pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM, 8'd255));
    pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM, 8'd170));
    pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM, 8'd85));
    pending_words.push_back(make_word(otsu_pkg::CMD_FINISH, 8'd255));
    pending_words.push_back(make_word(otsu_pkg::CMD_CLASSIFY, 8'd0));
    pending_words.push_back(make_word(otsu_pkg::CMD_CLASSIFY, 8'd255));
    pending_words.push_back(make_word(otsu_pkg::CMD_CLASSIFY, 8'd85));
    pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM, 8'd7));  // single value: threshold 0
    pending_words.push_back(make_word(otsu_pkg::CMD_ACCUM, 8'd7));
    pending_words.push_back(make_word(otsu_pkg::CMD_FINISH, 8'd0));
    pending_words.push_back(make_word(otsu_pkg::CMD_CLASSIFY, 8'd1));

    // Random frames: small ones mostly, finish scans are slow.
    sent = 0;
    while (sent < 820) begin
      int np, nc;
      np = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(20, 120);
      nc = $urandom_range(2, 30);
      queue_frame(np, nc);
      sent += np + nc + 1;
    end
    // final frame goes without idling
    queue_frame(60, 20);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (pending_words.size() < 100);
    quiet_tail = 1'b1;
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_words.size() == 0);
    repeat (4000) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== otsu_threshold_binarizer.f =====
sv/otsu_pkg.sv
sv/otsu_threshold_binarizer.sv
tb/sv/tb_otsu_threshold_binarizer.sv
